// ===== sv/tcbld_pkg.sv =====
// ----------------------------------------------------------------------------
// tcbld_pkg
// Shared types and constants for the tile cache LRU directory.
// ----------------------------------------------------------------------------
package tcbld_pkg;

   localparam int CACHE_ENTRIES = 64;
   localparam int EVICT_WANT    = CACHE_ENTRIES / 5;
   localparam int IDX_W         = $clog2(CACHE_ENTRIES);
   localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
   localparam int EVC_W         = $clog2(EVICT_WANT + 1);
   localparam int KEY_W         = 64;
   localparam int STAMP_W       = 64;
   localparam int SLOT_W        = 6;
   localparam int EVOUT_W       = 4;

   typedef struct packed {
      logic [11:0] glyph_x;
      logic [11:0] glyph_y;
      logic [7:0]  page_index;
      logic [23:0] tint_rgb;
   } req_item_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [EVOUT_W-1:0] evicted_count;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DECIDE,
      ST_EVICT,
      ST_DROP,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_step;
      logic evict_mode;
      logic hit_write;
      logic drop;
      logic insert;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic hit_found;
      logic full;
      logic evict_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== sv/tcbld_ram.sv =====
// ----------------------------------------------------------------------------
// tcbld_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcbld_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/tcbld_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcbld_ctrl
// Sequencer: lookup scan, batch eviction passes, insert and result load.
// ----------------------------------------------------------------------------
module tcbld_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcbld_pkg::status_type sts,
   output tcbld_pkg::cmd_type    cmd
);

   tcbld_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcbld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tcbld_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept     = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = tcbld_pkg::ST_LOOK;
            end
         end
         tcbld_pkg::ST_LOOK: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = tcbld_pkg::ST_DECIDE;
            end
         end
         tcbld_pkg::ST_DECIDE: begin
            if (sts.hit_found) begin
               cmd.hit_write = 1'b1;
               state_in      = tcbld_pkg::ST_FINISH;
            end else if (sts.full) begin
               cmd.scan_start = 1'b1;
               cmd.evict_mode = 1'b1;
               state_in       = tcbld_pkg::ST_EVICT;
            end else begin
               state_in = tcbld_pkg::ST_WRITE;
            end
         end
         tcbld_pkg::ST_EVICT: begin
            cmd.scan_step  = 1'b1;
            cmd.evict_mode = 1'b1;
            if (sts.scan_done) begin
               state_in = tcbld_pkg::ST_DROP;
            end
         end
         tcbld_pkg::ST_DROP: begin
            cmd.drop = 1'b1;
            if (sts.evict_last) begin
               state_in = tcbld_pkg::ST_WRITE;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.evict_mode = 1'b1;
               state_in       = tcbld_pkg::ST_EVICT;
            end
         end
         tcbld_pkg::ST_WRITE: begin
            cmd.insert = 1'b1;
            state_in   = tcbld_pkg::ST_FINISH;
         end
         tcbld_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tcbld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcbld_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/tcbld_dp.sv =====
// ----------------------------------------------------------------------------
// tcbld_dp
// Datapath: key/stamp memories, valid bits, scan trackers, result register.
// ----------------------------------------------------------------------------
module tcbld_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  tcbld_pkg::req_item_type req_item,
   input  tcbld_pkg::cmd_type      cmd,
   output tcbld_pkg::status_type   sts,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tcbld_pkg::rsp_item_type rsp_item
);

   localparam int IW = tcbld_pkg::IDX_W;
   localparam int CW = tcbld_pkg::CNT_W;
   localparam int EW = tcbld_pkg::EVC_W;

   logic [tcbld_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [tcbld_pkg::STAMP_W-1:0] ctr_ff;
   logic [tcbld_pkg::CACHE_ENTRIES-1:0] valid_ff;
   logic [CW-1:0] cnt_ff;
   logic          match_ff, free_found_ff, best_found_ff;
   logic [IW-1:0] match_idx_ff, free_idx_ff, best_idx_ff;
   logic [tcbld_pkg::STAMP_W-1:0] best_stamp_ff;
   logic [tcbld_pkg::KEY_W-1:0]   best_key_ff;
   logic [EW-1:0] evc_ff;
   logic          rsp_valid_ff;
   tcbld_pkg::rsp_item_type rsp_ff;

   logic [tcbld_pkg::KEY_W-1:0]   key_rd;
   logic [tcbld_pkg::STAMP_W-1:0] stamp_rd;
   logic [IW-1:0] idx;
   logic          cmp_en, ent_valid, older;
   logic          stamp_we;
   logic [IW-1:0] stamp_addr;
   logic [31:0]   key_high;

   assign key_high = 32'({4'b0, req_item.glyph_x, 16'b0}
                         ^ {20'b0, req_item.glyph_y}
                         ^ {24'b0, req_item.page_index});
   assign key_in   = {key_high, 8'hFF, req_item.tint_rgb};

   // compare stage trails the read address by one
   assign idx       = IW'(cnt_ff - CW'(1));
   assign cmp_en    = cmd.scan_step && (cnt_ff != '0);
   assign ent_valid = valid_ff[idx];
   assign older     = (stamp_rd < best_stamp_ff)
                    || ((stamp_rd == best_stamp_ff) && (key_rd < best_key_ff));

   assign stamp_we   = cmd.insert || cmd.hit_write;
   assign stamp_addr = cmd.hit_write ? match_idx_ff : free_idx_ff;

   tcbld_ram #(.WIDTH(tcbld_pkg::KEY_W), .DEPTH(tcbld_pkg::CACHE_ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (cmd.insert),
      .waddr (free_idx_ff),
      .wdata (key_ff),
      .raddr (cnt_ff[IW-1:0]),
      .rdata (key_rd)
   );

   tcbld_ram #(.WIDTH(tcbld_pkg::STAMP_W), .DEPTH(tcbld_pkg::CACHE_ENTRIES)) u_stamp_ram (
      .clock (clock),
      .we    (stamp_we),
      .waddr (stamp_addr),
      .wdata (ctr_ff),
      .raddr (cnt_ff[IW-1:0]),
      .rdata (stamp_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= key_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff.hit           <= match_ff;
         rsp_ff.slot          <= tcbld_pkg::SLOT_W'(match_ff ? match_idx_ff : free_idx_ff);
         rsp_ff.evicted_count <= tcbld_pkg::EVOUT_W'(evc_ff);
      end
      if (cmp_en && cmd.evict_mode && ent_valid && (!best_found_ff || older)) begin
         best_idx_ff   <= idx;
         best_stamp_ff <= stamp_rd;
         best_key_ff   <= key_rd;
      end
      if (cmp_en && !cmd.evict_mode && ent_valid && !match_ff
          && (key_rd == key_ff)) begin
         match_idx_ff <= idx;
      end
      if (cmp_en && !cmd.evict_mode && !ent_valid && !free_found_ff) begin
         free_idx_ff <= idx;
      end else if (cmd.drop && (!free_found_ff || (best_idx_ff < free_idx_ff))) begin
         free_idx_ff <= best_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff        <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         match_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         evc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            ctr_ff <= ctr_ff + 1'b1;
         end
         if (cmd.scan_start) begin
            cnt_ff        <= '0;
            best_found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (cmd.accept) begin
            match_ff      <= 1'b0;
            free_found_ff <= 1'b0;
            evc_ff        <= '0;
         end
         if (cmp_en && cmd.evict_mode && ent_valid) begin
            best_found_ff <= 1'b1;
         end
         if (cmp_en && !cmd.evict_mode && ent_valid && (key_rd == key_ff)) begin
            match_ff <= 1'b1;
         end
         if (cmp_en && !cmd.evict_mode && !ent_valid) begin
            free_found_ff <= 1'b1;
         end
         if (cmd.drop) begin
            valid_ff[best_idx_ff] <= 1'b0;
            free_found_ff         <= 1'b1;
            evc_ff                <= evc_ff + EW'(1);
         end
         if (cmd.insert) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.scan_done  = (cnt_ff == CW'(tcbld_pkg::CACHE_ENTRIES));
   assign sts.hit_found  = match_ff;
   assign sts.full       = !free_found_ff;
   assign sts.evict_last = (evc_ff == EW'(tcbld_pkg::EVICT_WANT - 1));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== sv/tile_cache_batch_lru_directory.sv =====
// Sequence: a hit makes one pass over the key memory, one key read per cycle, then
// decide/finish; a miss with a free slot makes the same pass, then decide/write/finish.
// A miss on a full directory adds CACHE_ENTRIES/5 eviction passes before the write,
// one stamp/key read per cycle.
// Throughput: one item at a time; the next is taken once the result is queued.
// Reset: valid bits, use counter and sequencer clear synchronously.
// ----------------------------------------------------------------------------
// tile_cache_batch_lru_directory
// Fully associative tile cache directory with LRU batch eviction.
// ----------------------------------------------------------------------------
module tile_cache_batch_lru_directory (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tcbld_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tcbld_pkg::rsp_item_type rsp_item
);

   // controller <-> datapath
   tcbld_pkg::cmd_type    cmd;
   tcbld_pkg::status_type sts;

   // sequencer: lookup scan, eviction passes, insert, result load
   tcbld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memories, valid bits, scan trackers and the output register
   tcbld_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
